// ----- hdl/keyed_watch_table_unit_macros.svh -----
// Assertion helpers shared by the watch table modules.
// All checks sample on clk and are off while arst_n is low.
`ifndef KEYED_WATCH_TABLE_UNIT_MACROS_SVH
`define KEYED_WATCH_TABLE_UNIT_MACROS_SVH

// Generic clocked property check.
`define KWT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition implies a consequence in the same cycle.
`define KWT_IMPLIES(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

// ----- hdl/kwt_pkg.sv -----
`default_nettype none
package kwt_pkg;

	// operation codes
	localparam logic [1:0] OP_UNKNOWN = 2'd0;
	localparam logic [1:0] OP_ADD     = 2'd1;
	localparam logic [1:0] OP_DEL     = 2'd2;
	localparam logic [1:0] OP_MOD     = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_BADF  = 3'd1;
	localparam logic [2:0] ST_EXIST = 3'd2;
	localparam logic [2:0] ST_NOSPC = 3'd3;
	localparam logic [2:0] ST_NOENT = 3'd4;
	localparam logic [2:0] ST_INVAL = 3'd5;

	localparam int MASK_BITS = 32;
	localparam int WORD_BITS = 64;
	localparam int KEY_PORT_BITS = 16;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic direct;
		logic scan_end;
	} sts_t;

endpackage
`default_nettype wire

// ----- hdl/kwt_ram.sv -----
`default_nettype none
module kwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/kwt_ctrl.sv -----
`default_nettype none
`include "keyed_watch_table_unit_macros.svh"
module kwt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire kwt_pkg::sts_t sts,
	output kwt_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);
	import kwt_pkg::*;

	state_t state_q, state_d;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_IDLE && start && sts.direct) || state_q == ST_COMMIT;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start && !sts.direct) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_end) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR:  cmd.clear  = 1'b1;
			ST_IDLE:   cmd.load   = start;
			ST_SCAN:   cmd.scan   = 1'b1;
			ST_COMMIT: cmd.commit = 1'b1;
			default:   cmd        = '0;
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;

	`KWT_IMPLIES(a_done_idle, done_q, state_q == ST_IDLE, "result strobe outside idle")
	`KWT_IMPLIES(a_done_src, done_q, $past(state_q == ST_COMMIT) || $past(state_q == ST_IDLE && start), "result strobe without request")
	`KWT_ASSERT(a_commit_once, (state_q == ST_COMMIT |=> state_q == ST_IDLE), "commit held over")
endmodule
`default_nettype wire

// ----- hdl/kwt_dp.sv -----
`default_nettype none
`include "keyed_watch_table_unit_macros.svh"
module kwt_dp #(
	parameter int ENTRIES = 64,
	parameter int KEY_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire kwt_pkg::cmd_t                         cmd,
	input  wire logic [1:0]                            kind,
	input  wire logic [kwt_pkg::KEY_PORT_BITS-1:0]     key,
	input  wire logic [kwt_pkg::MASK_BITS-1:0]         event_mask,
	input  wire logic [kwt_pkg::WORD_BITS-1:0]         user_word,
	input  wire logic                                  target_open,
	output kwt_pkg::sts_t                              sts,
	output logic [2:0]                                 status
);
	import kwt_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
	localparam int DW = MASK_BITS + WORD_BITS;
	localparam logic [AW:0]   LAST_CNT = (AW + 1)'(ENTRIES - 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

	// request registers
	logic [1:0]           kind_q;
	logic [KW-1:0]        key_q;
	logic [MASK_BITS-1:0] mask_q;
	logic [WORD_BITS-1:0] word_q;
	logic [2:0]           status_q;

	// scan state
	logic [AW:0]   addr_q;
	logic          pend_s1;
	logic [AW-1:0] idx_s1;
	logic          hit_q, free_q;
	logic [AW-1:0] hit_idx_q, free_idx_q;

	// key store: {valid, key}
	logic          key_we;
	logic [AW-1:0] key_waddr;
	logic [KW:0]   key_wdata;
	logic [KW:0]   key_rdata;
	logic          rd_valid;
	logic          match;

	// payload store: {mask, word}
	logic          dat_we;
	logic [AW-1:0] dat_waddr;
	logic [2:0]    commit_status;

	assign rd_valid = key_rdata[KW];
	assign match    = rd_valid && key_rdata[KW-1:0] == key_q;

	assign sts.direct     = (!target_open && kind != OP_DEL) || kind == OP_UNKNOWN;
	assign sts.clear_last = addr_q == LAST_CNT;
	assign sts.scan_end   = pend_s1 && (match || idx_s1 == LAST_IDX);

	always_comb begin
		commit_status = ST_OK;
		key_we        = 1'b0;
		key_waddr     = addr_q[AW-1:0];
		key_wdata     = '0;
		dat_we        = 1'b0;
		dat_waddr     = hit_idx_q;
		if (cmd.clear) begin
			key_we = 1'b1;
		end else if (cmd.commit) begin
			unique case (kind_q)
				OP_ADD: begin
					if (hit_q) begin
						commit_status = ST_EXIST;
					end else if (!free_q) begin
						commit_status = ST_NOSPC;
					end else begin
						key_we    = 1'b1;
						key_waddr = free_idx_q;
						key_wdata = {1'b1, key_q};
						dat_we    = 1'b1;
						dat_waddr = free_idx_q;
					end
				end
				OP_MOD: begin
					if (!hit_q) commit_status = ST_NOENT;
					else dat_we = 1'b1;
				end
				OP_DEL: begin
					if (!hit_q) begin
						commit_status = ST_NOENT;
					end else begin
						key_we    = 1'b1;
						key_waddr = hit_idx_q;
						key_wdata = {1'b0, key_q};
					end
				end
				default: commit_status = ST_INVAL;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			key_q    <= key[KW-1:0];
			mask_q   <= event_mask;
			word_q   <= user_word;
			status_q <= target_open ? ST_INVAL : ST_BADF;
		end else if (cmd.commit) begin
			status_q <= commit_status;
		end
		if (cmd.scan && addr_q <= LAST_CNT) begin
			idx_s1 <= addr_q[AW-1:0];
		end
		if (cmd.scan && pend_s1) begin
			if (match) begin
				hit_idx_q <= idx_s1;
			end else if (!rd_valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				addr_q  <= '0;
				pend_s1 <= 1'b0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end else if (cmd.clear) begin
				addr_q <= addr_q + 1'b1;
			end else if (cmd.scan) begin
				// issue one read per cycle, compare the one returned from last cycle
				if (addr_q <= LAST_CNT) begin
					addr_q  <= addr_q + 1'b1;
					pend_s1 <= 1'b1;
				end else begin
					pend_s1 <= 1'b0;
				end
				if (pend_s1) begin
					if (match) hit_q <= 1'b1;
					else if (!rd_valid) free_q <= 1'b1;
				end
			end
		end
	end

	kwt_ram #(
		.WIDTH(KW + 1),
		.DEPTH(ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.raddr(addr_q[AW-1:0]),
		.rdata(key_rdata)
	);

	// payload is kept for the event side; nothing here reads it back
	kwt_ram #(
		.WIDTH(DW),
		.DEPTH(ENTRIES)
	) u_dat_ram (
		.clk  (clk),
		.we   (dat_we),
		.waddr(dat_waddr),
		.wdata({mask_q, word_q}),
		.raddr(dat_waddr),
		.rdata()
	);

	assign status = status_q;

	`KWT_ASSERT(a_hit_seen, (cmd.scan && pend_s1 && match |=> hit_q), "key match lost in scan")
	`KWT_IMPLIES(a_add_slot, cmd.commit && kind_q == OP_ADD && !hit_q && free_q, key_we && key_waddr == free_idx_q, "add not written to free slot")
	`KWT_IMPLIES(a_no_write_miss, cmd.commit && !hit_q && kind_q != OP_ADD, !key_we && !dat_we, "table written on missing key")
endmodule
`default_nettype wire

// ----- hdl/keyed_watch_table_unit.sv -----
// channel   | signals                                           | handshake
// ----------+---------------------------------------------------+--------------------------
// request   | kind, key, event_mask, user_word, target_open     | start high while busy low
// result    | status                                            | done high for one cycle
//
// For a request that reaches the table, the key store is read one entry per cycle
// through its single registered read port, then the commit state writes back. A hit
// ends the scan early. Bad descriptor and unknown codes answer in the cycle after
// accept. After reset a clearing pass marks every entry invalid, with busy high.
// Results cannot be stalled.
`default_nettype none
module keyed_watch_table_unit #(
	parameter int ENTRIES = 64,
	parameter int KEY_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] key,
	input  wire logic [31:0] event_mask,
	input  wire logic [63:0] user_word,
	input  wire logic        target_open,
	output logic             done,
	output logic [2:0]       status
);
	import kwt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	kwt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	kwt_dp #(
		.ENTRIES (ENTRIES),
		.KEY_BITS(KEY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind),
		.key        (key),
		.event_mask (event_mask),
		.user_word  (user_word),
		.target_open(target_open),
		.sts        (sts),
		.status     (status)
	);
endmodule
`default_nettype wire

// ----- dv/keyed_watch_table_unit_test.sv -----
module keyed_watch_table_unit_test;
	import kwt_pkg::*;

	localparam int ENTRIES = 64;
	localparam int KEY_BITS = 16;
	localparam int RANDOM_REQUESTS = 1630;
	localparam int PHASE_LEN = 250;
	localparam int POOL_SIZE = 80;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = ENTRIES + 16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] key;
		logic [31:0] mask;
		logic [63:0] word;
		logic        is_open;
	} watch_req_t;

	typedef struct {
		watch_req_t req;
		bit         typed;
		logic [2:0] status;
	} plan_row_t;

	typedef struct {
		logic [2:0] status;
		int         seq;
	} status_slot_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = OP_UNKNOWN;
	logic [15:0] key = '0;
	logic [31:0] event_mask = '0;
	logic [63:0] user_word = '0;
	logic        target_open = 1'b0;
	logic        done;
	logic [2:0]  status;

	// predictor copy of the table
	logic                tbl_valid [ENTRIES];
	logic [KEY_BITS-1:0] tbl_key [ENTRIES];
	logic [31:0]         tbl_mask [ENTRIES];
	logic [63:0]         tbl_word [ENTRIES];

	status_slot_t expected_status[$];
	int           fault_count = 0;
	int           quiet_cycles = 0;
	int           req_seq = 0;
	logic [15:0]  key_pool [POOL_SIZE];

	keyed_watch_table_unit #(
		.ENTRIES(ENTRIES),
		.KEY_BITS(KEY_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.key(key),
		.event_mask(event_mask),
		.user_word(user_word),
		.target_open(target_open),
		.done(done),
		.status(status)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		fault_count++;
	endtask

	// Applies one request to the table copy and returns the status it must give.
	function automatic logic [2:0] apply_request(input watch_req_t r);
		logic [KEY_BITS-1:0] k;
		int hit_idx;
		int free_idx;
		k = r.key[KEY_BITS-1:0];
		hit_idx = -1;
		free_idx = -1;
		// closed target: only delete goes on to the table
		if (!r.is_open && r.kind != OP_DEL)
			return ST_BADF;
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_valid[i]) begin
				if (tbl_key[i] == k) begin
					hit_idx = i;
					break;
				end
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		case (r.kind)
			OP_ADD: begin
				if (hit_idx >= 0)
					return ST_EXIST;
				if (free_idx < 0)
					return ST_NOSPC;
				tbl_valid[free_idx] = 1'b1;
				tbl_key[free_idx] = k;
				tbl_mask[free_idx] = r.mask;
				tbl_word[free_idx] = r.word;
				return ST_OK;
			end
			OP_MOD: begin
				if (hit_idx < 0)
					return ST_NOENT;
				tbl_mask[hit_idx] = r.mask;
				tbl_word[hit_idx] = r.word;
				return ST_OK;
			end
			OP_DEL: begin
				if (hit_idx < 0)
					return ST_NOENT;
				// key, mask and word stay behind
				tbl_valid[hit_idx] = 1'b0;
				return ST_OK;
			end
			default: return ST_INVAL;
		endcase
	endfunction

	function automatic plan_row_t plan_entry(input logic [1:0] k, input logic [15:0] key_v,
			input logic [31:0] m, input logic [63:0] w, input logic o, input bit typed,
			input logic [2:0] st);
		plan_row_t p;
		p.req = '{kind: k, key: key_v, mask: m, word: w, is_open: o};
		p.typed = typed;
		p.status = st;
		return p;
	endfunction

	// Holds the request on the ports until it is taken, then records its status.
	task automatic issue(input watch_req_t r, input bit typed, input logic [2:0] typed_status);
		logic [2:0] predicted;
		status_slot_t slot;
		start <= 1'b1;
		kind <= r.kind;
		key <= r.key;
		event_mask <= r.mask;
		user_word <= r.word;
		target_open <= r.is_open;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = apply_request(r);
		slot.status = typed ? typed_status : predicted;
		slot.seq = req_seq;
		req_seq++;
		expected_status.push_back(slot);
	endtask

	always @(posedge clk) begin : status_check
		status_slot_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_status.size() == 0) begin
				report_mismatch($sformatf("status %0d with no request outstanding", status));
			end else begin
				want = expected_status.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("request %0d: status %0d, expected %0d",
						want.seq, status, want.status));
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		plan_row_t  plan[$];
		watch_req_t r;
		int         burst_left;
		int         gap;
		int         pick;
		bit         fill_phase;

		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_mask[i] = '0;
			tbl_word[i] = '0;
		end
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = 16'($urandom);
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hffff;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		plan.push_back(plan_entry(OP_DEL, 16'h0000, '0, '0, 1'b0, 1, ST_NOENT));
		plan.push_back(plan_entry(OP_MOD, 16'h0005, '0, '0, 1'b1, 1, ST_NOENT));
		plan.push_back(plan_entry(OP_UNKNOWN, 16'h0000, '0, '0, 1'b1, 1, ST_INVAL));
		plan.push_back(plan_entry(OP_UNKNOWN, 16'h0000, '0, '0, 1'b0, 1, ST_BADF));
		plan.push_back(plan_entry(OP_ADD, 16'h0000, '1, '1, 1'b0, 1, ST_BADF));
		plan.push_back(plan_entry(OP_MOD, 16'h0000, '1, '1, 1'b0, 1, ST_BADF));
		plan.push_back(plan_entry(OP_ADD, 16'h0000, '0, '0, 1'b1, 1, ST_OK));
		plan.push_back(plan_entry(OP_ADD, 16'h0000, '1, '1, 1'b1, 1, ST_EXIST));
		plan.push_back(plan_entry(OP_ADD, 16'hffff, '1, '1, 1'b1, 1, ST_OK));
		plan.push_back(plan_entry(OP_MOD, 16'hffff, '0, '0, 1'b1, 0, ST_OK));
		plan.push_back(plan_entry(OP_MOD, 16'h0000, 32'h5555_5555,
			64'haaaa_aaaa_aaaa_aaaa, 1'b1, 0, ST_OK));
		plan.push_back(plan_entry(OP_ADD, 16'h8001, 32'h8000_0001,
			64'h8000_0000_0000_0001, 1'b1, 0, ST_OK));
		// delete still goes through on a closed descriptor
		plan.push_back(plan_entry(OP_DEL, 16'h0000, '0, '0, 1'b0, 1, ST_OK));
		plan.push_back(plan_entry(OP_DEL, 16'h0000, '0, '0, 1'b1, 1, ST_NOENT));
		// stale key left in a freed slot must not match
		plan.push_back(plan_entry(OP_MOD, 16'h0000, '1, '1, 1'b1, 1, ST_NOENT));
		plan.push_back(plan_entry(OP_ADD, 16'h1234, 32'h0f0f_0f0f,
			64'h0123_4567_89ab_cdef, 1'b1, 0, ST_OK));
		plan.push_back(plan_entry(OP_DEL, 16'hffff, '0, '0, 1'b1, 0, ST_OK));
		plan.push_back(plan_entry(OP_UNKNOWN, 16'hffff, '1, '1, 1'b1, 1, ST_INVAL));
		plan.push_back(plan_entry(OP_DEL, 16'h8001, '0, '0, 1'b1, 0, ST_OK));
		plan.push_back(plan_entry(OP_DEL, 16'h1234, '0, '0, 1'b1, 0, ST_OK));

		foreach (plan[i])
			issue(plan[i].req, plan[i].typed, plan[i].status);

		// alternate add-heavy phases (table fills, no-space shows up) with delete-heavy ones
		burst_left = $urandom_range(1, 16);
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			fill_phase = ((n / PHASE_LEN) % 2) == 0;
			pick = $urandom_range(0, 99);
			if (fill_phase)
				r.kind = (pick < 65) ? OP_ADD : (pick < 75) ? OP_DEL :
					(pick < 95) ? OP_MOD : OP_UNKNOWN;
			else
				r.kind = (pick < 15) ? OP_ADD : (pick < 70) ? OP_DEL :
					(pick < 95) ? OP_MOD : OP_UNKNOWN;
			if ($urandom_range(0, 9) == 0)
				r.key = 16'($urandom);
			else
				r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			r.mask = $urandom;
			r.word = {$urandom, $urandom};
			r.is_open = ($urandom_range(0, 11) != 0);
			issue(r, 0, ST_OK);

			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 16);
			end else begin
				burst_left--;
			end
		end
		start <= 1'b0;

		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
